// ===== design/mftt_pkg.sv =====
// Shared constants and types for the motor feedback turn tracker.
package mftt_pkg;

  localparam int BYTE_W            = 8;
  localparam int ANGLE_W           = 16;
  localparam int RATE_W            = 7;
  localparam int TURN_W            = 16;
  localparam int TOTAL_W           = 30;
  localparam int DEG_W             = 35;

  localparam int COUNTS_PER_TURN   = 8192;
  localparam int TURN_BITS_DEFAULT = 16;

  // 360 deg / 8192 counts = 0.0439453125 deg = 45/1024 deg per count
  localparam int DEG_SCALE         = 45;

  // x / 1000 == (x * RECIP_MUL) >> RECIP_SHIFT, exact for x <= 59073
  localparam int RECIP_MUL         = 33555;
  localparam int RECIP_SHIFT       = 25;

  typedef struct packed {
    logic [TURN_W-1:0]  turn_count;
    logic [TOTAL_W-1:0] total_angle;
    logic [DEG_W-1:0]   angle_deg_q10;
  } turn_res_t;

endpackage

// ===== design/mftt_unpack.sv =====
// Frame field decode: angle word and scaled speed / torque current.
module mftt_unpack (
  input  logic [mftt_pkg::BYTE_W-1:0]         byte0,
  input  logic [mftt_pkg::BYTE_W-1:0]         byte1,
  input  logic [mftt_pkg::BYTE_W-1:0]         byte2,
  input  logic [mftt_pkg::BYTE_W-1:0]         byte3,
  input  logic [mftt_pkg::BYTE_W-1:0]         byte4,
  input  logic [mftt_pkg::BYTE_W-1:0]         byte5,
  output logic [mftt_pkg::ANGLE_W-1:0]        mech_angle,
  output logic signed [mftt_pkg::RATE_W-1:0]  speed,
  output logic signed [mftt_pkg::RATE_W-1:0]  torque_current
);
  import mftt_pkg::*;

  // signed word / 1000, truncated toward zero: divide the magnitude, restore sign
  function automatic logic [RATE_W-1:0] div_k(input logic [ANGLE_W-1:0] word);
    logic [ANGLE_W-1:0] mag;
    logic [31:0]        prod;
    logic [RATE_W-1:0]  q;
    mag  = word[ANGLE_W-1] ? -word : word;
    prod = 32'(mag) * 32'(RECIP_MUL);
    q    = RATE_W'(prod >> RECIP_SHIFT);
    return word[ANGLE_W-1] ? -q : q;
  endfunction

  assign mech_angle     = {byte0, byte1};
  assign speed          = div_k({byte2, byte3});
  assign torque_current = div_k({byte4, byte5});

endmodule

// ===== design/mftt_turns.sv =====
// Turn counter state and multi-turn angle / degree results.
module mftt_turns #(
  parameter int TURN_BITS = mftt_pkg::TURN_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic [mftt_pkg::ANGLE_W-1:0]  mech_angle,
  output mftt_pkg::turn_res_t           res
);
  import mftt_pkg::*;

  localparam int HALF_TURN = COUNTS_PER_TURN / 2;
  localparam int CMP_W     = ANGLE_W + 2;
  localparam logic [DEG_W-1:0] DEG_TURN_K = DEG_W'(longint'(COUNTS_PER_TURN) * DEG_SCALE);

  logic [ANGLE_W-1:0]          last_angle;
  logic [TURN_BITS-1:0]        turns;
  logic [TURN_BITS-1:0]        turns_next;
  logic [ANGLE_W-1:0]          diff;
  logic signed [CMP_W-1:0]     diff_x;
  logic signed [CMP_W-1:0]     half_pos;
  logic signed [CMP_W-1:0]     half_neg;
  logic signed [TURN_BITS-1:0] tv;
  logic [DEG_W-1:0]            tv_x;
  logic [DEG_W-1:0]            mech_x;
  logic [DEG_W-1:0]            total_x;

  // wrapped 16-bit step from the previous frame
  assign diff     = mech_angle - last_angle;
  assign diff_x   = CMP_W'($signed(diff));
  assign half_pos = CMP_W'(HALF_TURN);
  assign half_neg = -half_pos;

  always_comb begin
    turns_next = turns;
    if (diff_x > half_pos) begin
      turns_next = turns - 1'b1;
    end else if (diff_x < half_neg) begin
      turns_next = turns + 1'b1;
    end
  end

  assign tv      = $signed(turns_next);
  assign tv_x    = DEG_W'(tv);
  assign mech_x  = DEG_W'(mech_angle);
  assign total_x = tv_x * DEG_W'(COUNTS_PER_TURN) + mech_x;

  // degrees: (turns*C + m)*45 taken as turns*(45C) + 45m, both mod 2^35
  assign res.turn_count    = TURN_W'(tv);
  assign res.total_angle   = total_x[TOTAL_W-1:0];
  assign res.angle_deg_q10 = tv_x * DEG_TURN_K + mech_x * DEG_W'(DEG_SCALE);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_angle <= '0;
      turns      <= '0;
    end else if (advance) begin
      last_angle <= mech_angle;
      turns      <= turns_next;
    end
  end

endmodule

// ===== design/motor_feedback_turn_tracker_top.sv =====
// Top level of the motor feedback turn tracker: frame decode and multi-turn unwrap.
//
//   channel   handshake                 payload
//   -------   -----------------------   ---------------------------------------------
//   in        in_valid  / in_stall      byte0 .. byte7 (one 8-byte feedback frame)
//   out       out_valid / out_stall     mech_angle, speed, torque_current, motor_temp,
//                                       board_temp, turn_count, total_angle,
//                                       angle_deg_q10
//
// One request per cycle sustained while out_stall is low; each request passes through the input
// register and then the result register. The turn counter update feeds the constant multipliers combinationally.
// Synchronous reset clears both valid flags, the last angle and the turn counter.
// A stalled result holds in the result register while one more request waits in the
// input register; in_stall rises only when both are full and out_stall is high.
module motor_feedback_turn_tracker_top #(
  parameter int TURN_BITS = mftt_pkg::TURN_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mftt_pkg::BYTE_W-1:0]         byte0,
  input  logic [mftt_pkg::BYTE_W-1:0]         byte1,
  input  logic [mftt_pkg::BYTE_W-1:0]         byte2,
  input  logic [mftt_pkg::BYTE_W-1:0]         byte3,
  input  logic [mftt_pkg::BYTE_W-1:0]         byte4,
  input  logic [mftt_pkg::BYTE_W-1:0]         byte5,
  input  logic [mftt_pkg::BYTE_W-1:0]         byte6,
  input  logic [mftt_pkg::BYTE_W-1:0]         byte7,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mftt_pkg::ANGLE_W-1:0]        mech_angle,
  output logic signed [mftt_pkg::RATE_W-1:0]  speed,
  output logic signed [mftt_pkg::RATE_W-1:0]  torque_current,
  output logic [mftt_pkg::BYTE_W-1:0]         motor_temp,
  output logic [mftt_pkg::BYTE_W-1:0]         board_temp,
  output logic signed [mftt_pkg::TURN_W-1:0]  turn_count,
  output logic signed [mftt_pkg::TOTAL_W-1:0] total_angle,
  output logic signed [mftt_pkg::DEG_W-1:0]   angle_deg_q10
);
  import mftt_pkg::*;

  // input register
  logic               s1_valid;
  logic [BYTE_W-1:0]  s1_b0, s1_b1, s1_b2, s1_b3, s1_b4, s1_b5, s1_b6, s1_b7;

  logic               out_ready;
  logic               advance;

  logic [ANGLE_W-1:0]       dec_angle;
  logic signed [RATE_W-1:0] dec_speed;
  logic signed [RATE_W-1:0] dec_torque;
  turn_res_t                turn_res;

  // result register frees up when empty or being taken this cycle
  assign out_ready = !out_valid || !out_stall;
  assign advance   = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;

  mftt_unpack u_unpack (
    .byte0          (s1_b0),
    .byte1          (s1_b1),
    .byte2          (s1_b2),
    .byte3          (s1_b3),
    .byte4          (s1_b4),
    .byte5          (s1_b5),
    .mech_angle     (dec_angle),
    .speed          (dec_speed),
    .torque_current (dec_torque)
  );

  // turn state commits only when the request moves into the result register
  mftt_turns #(
    .TURN_BITS (TURN_BITS)
  ) u_turns (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .mech_angle (dec_angle),
    .res        (turn_res)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (out_ready) begin
        out_valid <= s1_valid;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_b0 <= byte0;
      s1_b1 <= byte1;
      s1_b2 <= byte2;
      s1_b3 <= byte3;
      s1_b4 <= byte4;
      s1_b5 <= byte5;
      s1_b6 <= byte6;
      s1_b7 <= byte7;
    end
    if (advance) begin
      mech_angle     <= dec_angle;
      speed          <= dec_speed;
      torque_current <= dec_torque;
      motor_temp     <= s1_b6;
      board_temp     <= s1_b7;
      turn_count     <= turn_res.turn_count;
      total_angle    <= turn_res.total_angle;
      angle_deg_q10  <= turn_res.angle_deg_q10;
    end
  end

endmodule

// ===== design/mftt_checker.sv =====
// Port-level checks for the motor feedback turn tracker, bound to the top level.
module mftt_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [mftt_pkg::ANGLE_W-1:0]        mech_angle,
  input logic signed [mftt_pkg::RATE_W-1:0]  speed,
  input logic signed [mftt_pkg::RATE_W-1:0]  torque_current,
  input logic [mftt_pkg::BYTE_W-1:0]         motor_temp,
  input logic [mftt_pkg::BYTE_W-1:0]         board_temp,
  input logic signed [mftt_pkg::TURN_W-1:0]  turn_count,
  input logic signed [mftt_pkg::TOTAL_W-1:0] total_angle,
  input logic signed [mftt_pkg::DEG_W-1:0]   angle_deg_q10
);
  import mftt_pkg::*;

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // back pressure only when a result is held and the sink is stalling
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // held result keeps all of its fields
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(turn_count)
      && $stable(total_angle) && $stable(angle_deg_q10) && $stable(mech_angle)
      && $stable(speed) && $stable(torque_current)
      && $stable(motor_temp) && $stable(board_temp)))
    else $error("stalled result changed");

  // a 16-bit word over 1000 lies within -32 .. 32
  a_rate_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (speed >= -7'sd32 && speed <= 7'sd32
      && torque_current >= -7'sd32 && torque_current <= 7'sd32))
    else $error("scaled speed or torque out of range");

endmodule

bind motor_feedback_turn_tracker_top mftt_checker u_mftt_checker (.*);
